// ===== design/pidc_pkg.sv =====
// Shared types and constants for the two-axis PID controller with clamp.
// Used by pidc_ctrl, pidc_axis and two_axis_pid_with_clamp_top; no dependencies.
package pidc_pkg;

	// Number of register stages from the input register to the output register.
	localparam int NUM_STAGES = 6;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Fixed field widths of the register set.
	localparam int GAIN_W = 16;
	localparam int COEF_W = 16;
	localparam int LIMIT_W = 15;
	localparam int CMD_W = 16;

	// Integral scale 0.03 in Q0.16 and derivative scale for a 30 Hz loop.
	localparam logic signed [11:0] I_SCALE = 12'sd1966;
	localparam logic signed [5:0] D_SCALE = 6'sd30;
	localparam int I_SCALE_SHIFT = 16;

	// Offset alignment (Q4.12 to the 2^-20 sum) and rounding of the sum back to Q4.12.
	localparam int ROUND_SHIFT = 8;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd4506;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_I       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_ROLL_OFFSET  = 3'd3,
		REG_TARGET_X     = 3'd4,
		REG_TARGET_Y     = 3'd5,
		REG_OUTPUT_LIMIT = 3'd6
	} pidc_reg_t;

	// Stage controls handed from the pipeline controller to each axis datapath.
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;    // stage k captures new data this cycle
		logic                  use_cmd; // item entering the output stage has a fresh command
	} pidc_ctl_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== design/pidc_ctrl.sv =====
// Pipeline controller: per-stage valid bits, ready chain and the primed flag.
// Depends on pidc_pkg.
module pidc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output pidc_pkg::pidc_ctl_t ctl
);
	import pidc_pkg::*;

	logic [NUM_STAGES-1:0]   valid_q;
	logic [NUM_STAGES-1:0]   ready;
	logic [NUM_STAGES-1:0]   load;
	logic [NUM_STAGES-2:1]   prim_q;
	logic                    primed_q;

	// A stage is free when it is empty or its content moves on this cycle.
	always_comb begin
		ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
		load[0] = ready[0] && in_valid;
		for (int k = 1; k < NUM_STAGES; k++) begin
			load[k] = ready[k] && valid_q[k-1];
		end
	end

	// Valid bits follow the data through the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ready[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (ready[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// The first item after reset only primes the state; later items carry a fresh command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			prim_q   <= '0;
		end else begin
			if (load[1]) begin
				primed_q  <= 1'b1;
				prim_q[1] <= primed_q;
			end
			for (int k = 2; k <= NUM_STAGES - 2; k++) begin
				if (load[k]) begin
					prim_q[k] <= prim_q[k-1];
				end
			end
		end
	end

	assign in_stall    = !ready[0];
	assign out_valid   = valid_q[NUM_STAGES-1];
	assign ctl.load    = load;
	assign ctl.use_cmd = prim_q[NUM_STAGES-2];

endmodule

// ===== design/pidc_axis.sv =====
// One axis of the PID controller: error, saturating integral, P/I/D terms, round and clamp.
// Depends on pidc_pkg; stage loads come from pidc_ctrl.
module pidc_axis #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int INTEGRAL_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pidc_pkg::pidc_ctl_t                    ctl,
	input  logic signed [SAMPLE_WIDTH-1:0]         pos,
	input  logic signed [pidc_pkg::COEF_W-1:0]     target,
	input  logic signed [pidc_pkg::GAIN_W-1:0]     gain_p,
	input  logic signed [pidc_pkg::GAIN_W-1:0]     gain_i,
	input  logic signed [pidc_pkg::GAIN_W-1:0]     gain_d,
	input  logic signed [pidc_pkg::COEF_W-1:0]     offset,
	input  logic        [pidc_pkg::LIMIT_W-1:0]    limit,
	output logic signed [pidc_pkg::CMD_W-1:0]      cmd
);
	import pidc_pkg::*;

	// Error, position step and integral widths.
	localparam int EW   = max_int(SAMPLE_WIDTH, COEF_W) + 1;
	localparam int DPW  = SAMPLE_WIDTH + 1;
	localparam int IW   = INTEGRAL_WIDTH;
	localparam int ISW  = max_int(IW, EW) + 1;
	// Product and term widths at the 2^-20 LSB.
	localparam int PW   = EW + GAIN_W;
	localparam int IPW  = IW + GAIN_W;
	localparam int IMW  = IPW + $bits(I_SCALE);
	localparam int QW   = IMW - I_SCALE_SHIFT;
	localparam int DPRW = DPW + GAIN_W;
	localparam int DW   = DPRW + $bits(D_SCALE);
	localparam int OW   = COEF_W + ROUND_SHIFT;
	localparam int SUMW = max_int(max_int(PW, QW), max_int(DW, OW)) + 3;
	localparam int CW   = SUMW - ROUND_SHIFT;

	localparam logic signed [IW-1:0]   INT_MAX   = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0]   INT_MIN   = {1'b1, {(IW-1){1'b0}}};
	localparam logic signed [SUMW-1:0] ROUND_BIAS = SUMW'(1) <<< (ROUND_SHIFT - 1);

	// Stage registers.
	logic signed [SAMPLE_WIDTH-1:0] pos_s1;
	logic signed [EW-1:0]           err_s2;
	logic signed [DPW-1:0]          dpos_s2;
	logic signed [IW-1:0]           integ_s2;
	logic signed [PW-1:0]           p_s3;
	logic signed [IPW-1:0]          prod_s3;
	logic signed [DPRW-1:0]         dprod_s3;
	logic signed [PW-1:0]           p_s4;
	logic signed [QW-1:0]           i_s4;
	logic signed [DW-1:0]           d_s4;
	logic signed [SUMW-1:0]         sum_s5;
	logic signed [CMD_W-1:0]        cmd_q;

	// Per-axis state.
	logic signed [IW-1:0]           integ_q;
	logic signed [SAMPLE_WIDTH-1:0] prev_q;

	// Combinational terms.
	logic signed [EW-1:0]           err;
	logic signed [DPW-1:0]          dpos;
	logic signed [ISW-1:0]          isum;
	logic signed [IW-1:0]           isat;
	logic signed [IMW-1:0]          iscaled;
	logic signed [DW-1:0]           d30;
	logic signed [OW-1:0]           off_aligned;
	logic signed [CW-1:0]           cmd_wide;
	logic signed [CW-1:0]           lim_pos;
	logic signed [CW-1:0]           lim_neg;
	logic signed [CW-1:0]           cmd_clamped;

	// Error against the setpoint, step since the last sample, and saturating integral.
	always_comb begin
		err  = EW'(pos_s1) - EW'(target);
		dpos = DPW'(pos_s1) - DPW'(prev_q);
		isum = ISW'(integ_q) + ISW'(err);
		if (isum > ISW'(INT_MAX)) begin
			isat = INT_MAX;
		end else if (isum < ISW'(INT_MIN)) begin
			isat = INT_MIN;
		end else begin
			isat = isum[IW-1:0];
		end
	end

	// Integral and previous sample advance as each item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (ctl.load[1]) begin
			integ_q <= isat;
			prev_q  <= pos_s1;
		end
	end

	// Integral scaling by 0.03 (floor) and derivative scaling by 30.
	always_comb begin
		iscaled     = IMW'(prod_s3) * IMW'(I_SCALE);
		d30         = DW'(dprod_s3) * DW'(D_SCALE);
		off_aligned = {offset, {ROUND_SHIFT{1'b0}}};
	end

	// Round half up to Q4.12 and clamp to the symmetric limit.
	always_comb begin
		cmd_wide = sum_s5[SUMW-1:ROUND_SHIFT];
		lim_pos  = CW'({1'b0, limit});
		lim_neg  = -lim_pos;
		if (cmd_wide > lim_pos) begin
			cmd_clamped = lim_pos;
		end else if (cmd_wide < lim_neg) begin
			cmd_clamped = lim_neg;
		end else begin
			cmd_clamped = cmd_wide;
		end
	end

	// Datapath stage registers; each captures when its stage loads.
	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			pos_s1 <= pos;
		end
		if (ctl.load[1]) begin
			err_s2   <= err;
			dpos_s2  <= dpos;
			integ_s2 <= isat;
		end
		if (ctl.load[2]) begin
			p_s3     <= PW'(err_s2) * PW'(gain_p);
			prod_s3  <= IPW'(integ_s2) * IPW'(gain_i);
			dprod_s3 <= DPRW'(dpos_s2) * DPRW'(gain_d);
		end
		if (ctl.load[3]) begin
			p_s4 <= p_s3;
			i_s4 <= iscaled[IMW-1:I_SCALE_SHIFT];
			d_s4 <= d30;
		end
		if (ctl.load[4]) begin
			sum_s5 <= SUMW'(p_s4) + SUMW'(i_s4) + SUMW'(d_s4) + SUMW'(off_aligned)
				+ ROUND_BIAS;
		end
		if (ctl.load[5]) begin
			cmd_q <= ctl.use_cmd ? cmd_clamped[CMD_W-1:0] : '0;
		end
	end

	assign cmd = cmd_q;

endmodule

// ===== design/two_axis_pid_with_clamp_top.sv =====
// Top level of the two-axis PID controller with clamped roll and pitch commands.
// Depends on pidc_pkg, pidc_ctrl and pidc_axis.
//
//   Channel  Handshake                Payload
//   input    in_valid / in_stall      pos_x, pos_y
//   output   out_valid / out_stall    roll_cmd, pitch_cmd
//   config   cfg_wr_en                cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_stall is low; each result passes from the input register
// through the error, product, term and sum registers to the output register. The rate is one item per cycle
// unless stalled, set by the integral accumulator, which updates as each item leaves the input register.
// Reset clears the valid bits, integrals, previous samples, primed flag, gains, offset and targets.
// A stalled output holds its result; stages behind it keep filling until the pipe is full.
module two_axis_pid_with_clamp_top #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int INTEGRAL_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]          pos_x,
	input  logic signed [SAMPLE_WIDTH-1:0]          pos_y,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [pidc_pkg::CMD_W-1:0]       roll_cmd,
	output logic signed [pidc_pkg::CMD_W-1:0]       pitch_cmd,
	input  logic                                    cfg_wr_en,
	input  logic        [pidc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic        [pidc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pidc_pkg::*;

	logic signed [GAIN_W-1:0] gain_p_q;
	logic signed [GAIN_W-1:0] gain_i_q;
	logic signed [GAIN_W-1:0] gain_d_q;
	logic signed [COEF_W-1:0] roll_offset_q;
	logic signed [COEF_W-1:0] target_x_q;
	logic signed [COEF_W-1:0] target_y_q;
	logic        [LIMIT_W-1:0] output_limit_q;
	pidc_ctl_t                ctl;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= '0;
			gain_i_q       <= '0;
			gain_d_q       <= '0;
			roll_offset_q  <= '0;
			target_x_q     <= '0;
			target_y_q     <= '0;
			output_limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (pidc_reg_t'(cfg_index))
				REG_GAIN_P:       gain_p_q       <= cfg_data;
				REG_GAIN_I:       gain_i_q       <= cfg_data;
				REG_GAIN_D:       gain_d_q       <= cfg_data;
				REG_ROLL_OFFSET:  roll_offset_q  <= cfg_data;
				REG_TARGET_X:     target_x_q     <= cfg_data;
				REG_TARGET_Y:     target_y_q     <= cfg_data;
				REG_OUTPUT_LIMIT: output_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Shared stage control for both axes.
	pidc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// Roll from x, with the roll offset.
	pidc_axis #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pos    (pos_x),
		.target (target_x_q),
		.gain_p (gain_p_q),
		.gain_i (gain_i_q),
		.gain_d (gain_d_q),
		.offset (roll_offset_q),
		.limit  (output_limit_q),
		.cmd    (roll_cmd)
	);

	// Pitch from y, without offset.
	pidc_axis #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pos    (pos_y),
		.target (target_y_q),
		.gain_p (gain_p_q),
		.gain_i (gain_i_q),
		.gain_d (gain_d_q),
		.offset ('0),
		.limit  (output_limit_q),
		.cmd    (pitch_cmd)
	);

endmodule
